@@ design/pwm_audio_fifo_device_defines.svh @@
// Assertion macros used by the top-level design file.
`ifndef PWM_AUDIO_FIFO_DEVICE_DEFINES_SVH
`define PWM_AUDIO_FIFO_DEVICE_DEFINES_SVH

// A property that must hold at every clock edge outside reset.
`define PAF_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// A property checked even while reset is held.
`define PAF_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

@@ design/paf_pkg.sv @@
`timescale 1ns / 1ps
package paf_pkg;
    localparam logic [1:0] OP_READ  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;

    localparam logic [2:0] REG_CTRL  = 3'd0;
    localparam logic [2:0] REG_CYCLE = 3'd1;
    localparam logic [2:0] REG_LEFT  = 3'd2;
    localparam logic [2:0] REG_RIGHT = 3'd3;
    localparam logic [2:0] REG_MONO  = 3'd4;

    localparam logic [1:0] MODE_LOCKED  = 2'd0;
    localparam logic [1:0] MODE_STOPPED = 2'd1;
    localparam logic [1:0] MODE_LOW     = 2'd2;
    localparam logic [1:0] MODE_HIGH    = 2'd3;

    localparam int SCALE_W = 25;
    localparam logic [SCALE_W-1:0] SCALE_NUM = 25'h1000000;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       load;      // register the accepted item
        logic       exec;      // perform the item's state update
        logic       div_start; // begin the scale division
        logic       div_step;  // one quotient bit
        logic       div_done;  // store quotient and finish settings
        logic       emit;      // present the result
    } t_cmd;

    typedef struct packed {
        logic       need_div;  // item is a control or cycle write
        logic       has_result;
        logic       div_last;
    } t_status;
endpackage

@@ design/pwm_audio_fifo_device.sv @@
`timescale 1ns / 1ps
// Channel        | Direction | Handshake                        | Payload
// item command   | in        | i_start accepted when !o_busy    | operation, offset, data
// result         | out       | o_done strobe, one cycle         | read data, levels, flags
// configuration  | in/out    | APB write, pready always high    | irq_adapt_enable
//
// A read or tick passes through the load, update and output states before its result
// strobe; a write to a sample register, or an ignored operation, passes through load and
// update only. A control or cycle write also runs the bit-serial scale divider (one quotient
// bit per cycle over 25 bits) after divider setup, and ends with a finish step.
// Reset is synchronous and active low and needs no clearing pass.
// The receiver cannot stall: each result is shown for exactly one cycle.
module pwm_audio_fifo_device (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [1:0]  i_operation,
    input  logic [2:0]  i_reg_offset,
    input  logic [15:0] i_write_data,
    output logic        o_done,
    output logic [15:0] o_read_data,
    output logic signed [15:0] o_left_level,
    output logic signed [15:0] o_right_level,
    output logic        o_sample_valid,
    output logic        o_irq_pulse,
    output logic        o_dreq_pulse,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import paf_pkg::*;
    `include "pwm_audio_fifo_device_defines.svh"

    t_cmd    cmd;
    t_status status;
    logic    r_adapt_en;

    // The configuration register holds the adaptive reload option; it is
    // sampled only when a control or cycle write completes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_adapt_en <= 1'b0;
        end else if (psel && penable && pwrite && !paddr) begin
            r_adapt_en <= pwdata[0];
        end
    end

    assign pready = 1'b1;
    assign prdata = paddr ? 32'd0 : {31'd0, r_adapt_en};

    paf_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (o_busy)
    );

    logic [15:0] lvl_l, lvl_r;

    paf_datapath u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_operation    (i_operation),
        .i_reg_offset   (i_reg_offset),
        .i_write_data   (i_write_data),
        .i_adapt_en     (r_adapt_en),
        .o_read_data    (o_read_data),
        .o_left_level   (lvl_l),
        .o_right_level  (lvl_r),
        .o_sample_valid (o_sample_valid),
        .o_irq_pulse    (o_irq_pulse),
        .o_dreq_pulse   (o_dreq_pulse),
        .o_strobe       (o_done)
    );

    assign o_left_level  = $signed(lvl_l);
    assign o_right_level = $signed(lvl_r);

    // A result strobe only follows an emit command of the previous cycle.
    `PAF_ASSERT(a_done_after_emit, o_done |-> $past(cmd.emit), "result without emit")
    // A dreq pulse never comes without an irq pulse.
    `PAF_ASSERT(a_dreq_irq, (o_done && o_dreq_pulse) |-> o_irq_pulse, "dreq without irq")
    // A new transaction is only taken while idle.
    `PAF_ASSERT(a_load_idle, cmd.load |-> !o_busy, "load while busy")
endmodule

@@ design/paf_ctrl.sv @@
`timescale 1ns / 1ps
module paf_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  paf_pkg::t_status  i_status,
    output paf_pkg::t_cmd     o_cmd,
    output logic              o_busy
);
    import paf_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXEC = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_FIN  = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;
    localparam logic [2:0] S_DST  = 3'd5;

    logic [2:0] r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                if (i_status.need_div) begin
                    n_state = S_DST;
                end else if (i_status.has_result) begin
                    n_state = S_OUT;
                end else begin
                    n_state = S_IDLE;
                end
            end
            // The divider is set up only once the new period is in place.
            S_DST: begin
                o_cmd.div_start = 1'b1;
                n_state = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_last) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                o_cmd.div_done = 1'b1;
                n_state = S_IDLE;
            end
            S_OUT: begin
                o_cmd.emit = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_busy = (r_state != S_IDLE);
endmodule

@@ design/paf_datapath.sv @@
`timescale 1ns / 1ps
module paf_datapath (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  paf_pkg::t_cmd     i_cmd,
    output paf_pkg::t_status  o_status,
    input  logic [1:0]        i_operation,
    input  logic [2:0]        i_reg_offset,
    input  logic [15:0]       i_write_data,
    input  logic              i_adapt_en,
    output logic [15:0]       o_read_data,
    output logic [15:0]       o_left_level,
    output logic [15:0]       o_right_level,
    output logic              o_sample_valid,
    output logic              o_irq_pulse,
    output logic              o_dreq_pulse,
    output logic              o_strobe
);
    import paf_pkg::*;

    logic [1:0]  r_op;
    logic [2:0]  r_reg;
    logic [15:0] r_data;

    logic [15:0] r_ctrl;
    logic [11:0] r_period;
    logic [SCALE_W-1:0] r_scale;
    logic [11:0] r_lq [4];
    logic [11:0] r_rq [4];
    logic [1:0]  r_lhead, r_rhead, r_lfill, r_rfill;
    logic [15:0] r_lcur, r_rcur;
    logic [4:0]  r_cnt, r_reload, r_prog;
    logic [1:0]  r_mode;
    logic        r_ctrl_write;

    // Restoring divider: 2^24 / (P + 1), one quotient bit per cycle.
    logic [SCALE_W-1:0] r_quot;
    logic [12:0]        r_rem;
    logic [4:0]         r_bit;
    logic [12:0]        r_divisor;

    logic [15:0] r_rd;
    logic        r_valid, r_irq, r_dreq, r_strobe;

    logic [11:0] per;
    assign per = r_period - 12'd1;

    logic is_write, is_tick, is_read;
    assign is_write = (r_op == OP_WRITE);
    assign is_tick  = (r_op == OP_TICK);
    assign is_read  = (r_op == OP_READ);

    assign o_status.need_div   = is_write && (r_reg == REG_CTRL || r_reg == REG_CYCLE);
    assign o_status.has_result = is_read || is_tick;
    assign o_status.div_last   = (r_bit == 5'd0);

    function automatic logic [15:0] flags(input logic [1:0] f);
        if (f == 2'd3) return 16'h8000;
        if (f == 2'd0) return 16'h4000;
        return 16'h0000;
    endfunction

    // Clamp and scale one sample to a level.
    function automatic logic [15:0] scale(input logic [11:0] v, input logic [11:0] p,
                                          input logic [SCALE_W-1:0] s);
        logic [11:0] c;
        logic [36:0] m;
        c = (v > p) ? p : v;
        m = {25'd0, c} * {12'd0, s};
        return m[23:8] - 16'h8000;
    endfunction

    logic [12:0] trial;
    assign trial = {r_rem[11:0], SCALE_NUM[r_bit]};

    logic [1:0] lnext, rnext;
    assign lnext = r_lhead + 2'd1;
    assign rnext = r_rhead + 2'd1;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op   <= i_operation;
            r_reg  <= i_reg_offset;
            r_data <= i_write_data;
        end
        r_strobe <= i_cmd.emit;
        if (i_cmd.exec) begin
            r_rd <= '0;
            r_valid <= 1'b0;
            r_irq <= 1'b0;
            r_dreq <= 1'b0;
        end
        if (!i_rst_n) begin
            r_ctrl <= '0; r_period <= '0; r_scale <= '0;
            r_lhead <= '0; r_rhead <= '0; r_lfill <= '0; r_rfill <= '0;
            r_lcur <= '0; r_rcur <= '0; r_cnt <= '0;
            r_reload <= 5'd1; r_prog <= 5'd1; r_mode <= MODE_LOCKED;
            r_strobe <= 1'b0; r_ctrl_write <= 1'b0;
            r_bit <= '0;
            for (int i = 0; i < 4; i++) begin
                r_lq[i] <= '0;
                r_rq[i] <= '0;
            end
        end else if (i_cmd.exec) begin
            r_ctrl_write <= 1'b0;
            if (is_write) begin
                case (r_reg)
                    REG_CTRL: begin
                        if (r_ctrl[3:0] == 4'd0) begin
                            r_lq[0] <= '0;
                            r_rq[0] <= '0;
                        end
                        r_ctrl <= r_data;
                        r_ctrl_write <= 1'b1;
                    end
                    REG_CYCLE: r_period <= r_data[11:0];
                    REG_LEFT, REG_RIGHT, REG_MONO: begin
                        if (r_reg != REG_LEFT) begin
                            if (r_rfill < 2'd3) begin
                                if (r_rfill == 2'd2 && r_mode >= MODE_STOPPED) begin
                                    if (r_reload < 5'd3 && r_mode == MODE_HIGH)
                                        r_reload <= r_reload + 5'd1;
                                    r_mode <= MODE_HIGH;
                                end
                                r_rfill <= r_rfill + 2'd1;
                                r_rq[r_rhead + r_rfill + 2'd1] <= r_data[11:0] - 12'd1;
                            end else begin
                                r_reload <= r_prog;
                                r_mode <= MODE_LOCKED;
                                r_rhead <= rnext;
                                r_rq[rnext + r_rfill] <= r_data[11:0] - 12'd1;
                            end
                        end
                        if (r_reg != REG_RIGHT) begin
                            if (r_lfill < 2'd3) begin
                                r_lfill <= r_lfill + 2'd1;
                                r_lq[r_lhead + r_lfill + 2'd1] <= r_data[11:0] - 12'd1;
                            end else begin
                                r_lhead <= lnext;
                                r_lq[lnext + r_lfill] <= r_data[11:0] - 12'd1;
                            end
                        end
                    end
                    default: ;
                endcase
            end else if (is_read) begin
                case (r_reg)
                    REG_CTRL:  r_rd <= r_ctrl;
                    REG_CYCLE: r_rd <= {4'd0, r_period};
                    REG_LEFT:  r_rd <= flags(r_lfill);
                    REG_RIGHT, REG_MONO: r_rd <= flags(r_rfill);
                    default:   r_rd <= '0;
                endcase
            end else if (is_tick && per != 12'd0) begin
                r_valid <= 1'b1;
                if (r_lfill != 2'd0) begin
                    r_lhead <= lnext;
                    r_lfill <= r_lfill - 2'd1;
                    r_lcur  <= scale(r_lq[lnext], per, r_scale);
                end
                if (r_rfill != 2'd0) begin
                    r_rhead <= rnext;
                    r_rfill <= r_rfill - 2'd1;
                    r_rcur  <= scale(r_rq[rnext], per, r_scale);
                end
                if (r_cnt <= 5'd1) begin
                    r_cnt <= r_reload;
                    r_irq <= 1'b1;
                    r_dreq <= r_ctrl[7];
                end else begin
                    r_cnt <= r_cnt - 5'd1;
                    if ((r_rfill == 2'd0 || (r_rfill == 2'd1)) && r_mode >= MODE_LOW) begin
                        if (r_rfill == 2'd1 || r_rfill == 2'd0) begin
                            if (r_reload > r_prog) r_reload <= r_reload - 5'd1;
                            r_mode <= MODE_LOW;
                        end
                    end
                end
            end
        end else if (i_cmd.div_start) begin
            r_bit <= 5'd24;
        end else if (i_cmd.div_step) begin
            if (r_bit != 5'd0) r_bit <= r_bit - 5'd1;
        end else if (i_cmd.div_done) begin
            r_scale  <= (r_ctrl[3:0] != 4'd0) ? r_quot : '0;
            r_prog   <= {1'b0, r_ctrl[11:8] - 4'd1} + 5'd1;
            r_reload <= {1'b0, r_ctrl[11:8] - 4'd1} + 5'd1;
            r_mode   <= i_adapt_en ? MODE_STOPPED : MODE_LOCKED;
            if (r_ctrl_write || r_cnt == 5'd0)
                r_cnt <= {1'b0, r_ctrl[11:8] - 4'd1} + 5'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_divisor <= {1'b0, per} + 13'd1;
            r_rem  <= '0;
            r_quot <= '0;
        end else if (i_cmd.div_step) begin
            if (trial >= r_divisor) begin
                r_rem <= trial - r_divisor;
                r_quot[r_bit] <= 1'b1;
            end else begin
                r_rem <= trial;
            end
        end
    end

    assign o_read_data    = r_rd;
    assign o_left_level   = r_lcur;
    assign o_right_level  = r_rcur;
    assign o_sample_valid = r_valid;
    assign o_irq_pulse    = r_irq;
    assign o_dreq_pulse   = r_dreq;
    assign o_strobe       = r_strobe;
endmodule
